>>> hw/rtl/can_bit_timing_solver_defines.svh
// ----------------------------------------------------------------------------
// CAN bit timing solver assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CAN_BIT_TIMING_SOLVER_DEFINES_SVH
`define CAN_BIT_TIMING_SOLVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CBTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CBTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/cbts_pkg.sv
// ----------------------------------------------------------------------------
// CAN bit timing solver package
// Types and constants shared by the solver and its checker, and the solver's segment table.
// ----------------------------------------------------------------------------
`default_nettype none

package cbts_pkg;

   localparam logic [31:0] PCLK_RESET_HZ = 32'd48000000;
   localparam logic [31:0] FAST_RATE_HZ  = 32'd1000000;
   // quanta per bit minus one at the start of the search
   localparam logic [4:0]  SUM_FAST      = 5'd9;
   localparam logic [4:0]  SUM_SLOW      = 5'd16;
   localparam int          Q_MIN         = 3;
   localparam int          LANES         = 15;
   localparam logic [10:0] PRESC_MAX     = 11'd1024;
   localparam logic [9:0]  SP_MIN        = 10'd666;
   localparam logic [9:0]  SP_LIMIT      = 10'd900;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_RATE   = 2'd1,
      STATUS_CHECK_FAIL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SEL,
      ST_PRE,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [3:0] seg1_code;
      logic [2:0] seg2_code;
      logic [9:0] sp_permill;
   } seg_type;

   // Segment split per quanta-count-minus-one, sample point near 7/8,
   // rounded toward zero where nearest would exceed 900 permill.
   function automatic seg_type seg_lookup(input logic [4:0] sum);
      seg_type r;
      unique case (sum)
         5'd2:    r = '{4'd0,  3'd0, 10'd666};
         5'd3:    r = '{4'd1,  3'd0, 10'd750};
         5'd4:    r = '{4'd2,  3'd0, 10'd800};
         5'd5:    r = '{4'd3,  3'd0, 10'd833};
         5'd6:    r = '{4'd4,  3'd0, 10'd857};
         5'd7:    r = '{4'd5,  3'd0, 10'd875};
         5'd8:    r = '{4'd6,  3'd0, 10'd888};
         5'd9:    r = '{4'd7,  3'd0, 10'd900};
         5'd10:   r = '{4'd7,  3'd1, 10'd818};
         5'd11:   r = '{4'd8,  3'd1, 10'd833};
         5'd12:   r = '{4'd9,  3'd1, 10'd846};
         5'd13:   r = '{4'd10, 3'd1, 10'd857};
         5'd14:   r = '{4'd11, 3'd1, 10'd866};
         5'd15:   r = '{4'd12, 3'd1, 10'd875};
         5'd16:   r = '{4'd13, 3'd1, 10'd882};
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/can_bit_timing_solver.sv
// ----------------------------------------------------------------------------
// CAN bit timing solver
// Turns a requested bitrate into prescaler / SJW / segment register codes.
// ----------------------------------------------------------------------------
//  channel  | direction | signals                          | transfer when
//  ---------+-----------+----------------------------------+-------------------
//  req      | in        | req_tvalid/tready/tdata          | tvalid & tready
//  rsp      | out       | rsp_tvalid/tready/tdata/tuser    | tvalid & tready
//  csr      | in        | csr_wr_en/csr_wr_data            | csr_wr_en
//
//  One request at a time. A nonzero bitrate runs through ST_DIV, the bit-serial
//  pclk/bitrate divide (quotient bits also feed 15 remainder lanes, one per
//  quanta count), then ST_SEL, the quanta search, then ST_PRE, the bit-serial
//  prescaler divide, then ST_FIN, which forms the result. A zero bitrate goes
//  straight to ST_FIN. Sync reset restores pclk_hz to 48 MHz and clears the
//  handshakes. A stalled result holds in the output register while the next
//  request is accepted; that request waits in ST_FIN for the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module can_bit_timing_solver
   import cbts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,   // pclk_hz
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,     // [31:0] target_bitrate_hz
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [9:0] prescaler_code, [11:10] sjw_code, [15:12] seg1_code,
   // [18:16] seg2_code, [28:19] sp_permill, [31:29] zero
   output logic [31:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser      // [1:0] status
);

   state_type   state_ff, state_in;
   logic [31:0] pclk_ff;
   logic [31:0] rate_ff,  rate_in;
   logic [31:0] num_ff,   num_in;
   logic [31:0] rem_ff,   rem_in;
   logic [31:0] quo_ff,   quo_in;
   logic [4:0]  cnt_ff,   cnt_in;
   logic        zero_ff,  zero_in;
   logic        fast_ff,  fast_in;
   logic [4:0]  lane_rem_ff [LANES];
   logic [4:0]  lane_rem_in [LANES];
   logic [4:0]  sum_ff,   sum_in;
   logic        found_ff, found_in;
   logic [4:0]  pr_rem_ff, pr_rem_in;
   logic [10:0] presc_ff, presc_in;
   logic        ovf_ff,   ovf_in;
   logic        cmp_done_ff, cmp_done_in;
   logic        cmp_ge_ff,   cmp_ge_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff,  rsp_data_in;
   logic [1:0]  rsp_user_ff,  rsp_user_in;

   logic        accept;
   logic        slot_free;
   logic [32:0] div_sh;
   logic        div_ge;
   logic [5:0]  lane_sh [LANES];
   logic [4:0]  start_sum;
   logic        sel_found;
   logic [4:0]  sel_sum;
   logic [5:0]  pr_sh;
   logic        pr_ge;
   logic [5:0]  q6;
   seg_type     seg;
   logic        presc_bad;
   logic        recheck_bad;
   status_type  res_status;

   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // restoring divide step: one quotient bit per cycle
   assign div_sh = {rem_ff, num_ff[31]};
   assign div_ge = div_sh >= {1'b0, rate_ff};

   // remainder lanes track quotient mod q for every candidate q
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         lane_sh[i] = {lane_rem_ff[i], div_ge};
         if (lane_sh[i] >= 6'(i + Q_MIN)) begin
            lane_rem_in[i] = 5'(lane_sh[i] - 6'(i + Q_MIN));
         end else begin
            lane_rem_in[i] = lane_sh[i][4:0];
         end
      end
   end

   // largest quanta count not above the start value that divides evenly
   assign start_sum = fast_ff ? SUM_FAST : SUM_SLOW;
   always_comb begin
      sel_found = 1'b0;
      sel_sum   = '0;
      for (int i = 0; i < LANES; i++) begin
         if (lane_rem_ff[i] == 5'd0 && 5'(i + Q_MIN - 1) <= start_sum) begin
            sel_found = 1'b1;
            sel_sum   = 5'(i + Q_MIN - 1);
         end
      end
   end

   // prescaler divide step by the selected quanta count
   assign q6    = {1'b0, sum_ff} + 6'd1;
   assign pr_sh = {pr_rem_ff, quo_ff[31]};
   assign pr_ge = pr_sh >= q6;

   // result formation
   assign seg         = seg_lookup(sum_ff);
   assign presc_bad   = ovf_ff || presc_ff > PRESC_MAX || presc_ff == 11'd0;
   // pclk / quotient == rate exactly when the divide remainder is below the quotient
   assign recheck_bad = cmp_done_ff ? cmp_ge_ff : 1'b1;

   always_comb begin
      if (zero_ff || !found_ff || presc_bad) begin
         res_status = STATUS_BAD_RATE;
      end else if (recheck_bad) begin
         res_status = STATUS_CHECK_FAIL;
      end else begin
         res_status = STATUS_OK;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rate_in      = rate_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      zero_in      = zero_ff;
      fast_in      = fast_ff;
      sum_in       = sum_ff;
      found_in     = found_ff;
      pr_rem_in    = pr_rem_ff;
      presc_in     = presc_ff;
      ovf_in       = ovf_ff;
      cmp_done_in  = cmp_done_ff;
      cmp_ge_in    = cmp_ge_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               rate_in  = req_tdata;
               num_in   = pclk_ff;
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = '0;
               zero_in  = req_tdata == 32'd0;
               fast_in  = req_tdata >= FAST_RATE_HZ;
               state_in = (req_tdata == 32'd0) ? ST_FIN : ST_DIV;
            end
         end
         ST_DIV: begin
            num_in = {num_ff[30:0], 1'b0};
            rem_in = div_ge ? 32'(div_sh - {1'b0, rate_ff}) : div_sh[31:0];
            quo_in = {quo_ff[30:0], div_ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            sum_in      = sel_sum;
            found_in    = sel_found;
            pr_rem_in   = '0;
            presc_in    = '0;
            ovf_in      = 1'b0;
            cmp_done_in = 1'b0;
            cmp_ge_in   = 1'b0;
            cnt_in      = '0;
            state_in    = ST_PRE;
         end
         ST_PRE: begin
            quo_in    = {quo_ff[30:0], 1'b0};
            rem_in    = {rem_ff[30:0], 1'b0};
            pr_rem_in = pr_ge ? 5'(pr_sh - q6) : pr_sh[4:0];
            presc_in  = {presc_ff[9:0], pr_ge};
            ovf_in    = ovf_ff || presc_ff[10];
            // MSB-first compare of remainder against the pclk/bitrate quotient
            if (!cmp_done_ff && rem_ff[31] != quo_ff[31]) begin
               cmp_done_in = 1'b1;
               cmp_ge_in   = rem_ff[31];
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_status;
               if (res_status == STATUS_OK) begin
                  rsp_data_in = {3'd0, seg.sp_permill, seg.seg2_code, seg.seg1_code,
                                 2'd0, 10'(presc_ff - 11'd1)};
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pclk_ff      <= PCLK_RESET_HZ;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            pclk_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rate_ff     <= rate_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      zero_ff     <= zero_in;
      fast_ff     <= fast_in;
      sum_ff      <= sum_in;
      found_ff    <= found_in;
      pr_rem_ff   <= pr_rem_in;
      presc_ff    <= presc_in;
      ovf_ff      <= ovf_in;
      cmp_done_ff <= cmp_done_in;
      cmp_ge_ff   <= cmp_ge_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      for (int i = 0; i < LANES; i++) begin
         if (state_ff == ST_IDLE) begin
            lane_rem_ff[i] <= '0;
         end else if (state_ff == ST_DIV) begin
            lane_rem_ff[i] <= lane_rem_in[i];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

>>> hw/rtl/cbts_checker.sv
// ----------------------------------------------------------------------------
// CAN bit timing solver port checker
// Watches the solver's handshakes and result codes over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "can_bit_timing_solver_defines.svh"

module cbts_checker
   import cbts_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   `CBTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   `CBTS_ASSERT_NOW(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser != STATUS_OK, rsp_tdata == 32'd0, "error result carries nonzero codes")

   `CBTS_ASSERT_NOW(a_ok_range, clock, reset, rsp_tvalid && rsp_tuser == STATUS_OK, rsp_tdata[11:10] == 2'd0 && rsp_tdata[28:19] >= SP_MIN && rsp_tdata[28:19] <= SP_LIMIT && rsp_tdata[31:29] == 3'd0, "ok result out of range")

   `CBTS_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while busy")

endmodule

bind can_bit_timing_solver cbts_checker u_cbts_checker (.*);

`default_nettype wire
